@@ design/parameterized_crc_engine_core_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the parameterized CRC engine
// Shared property forms used by the port checker.
// ---------------------------------------------------------------------------
`ifndef PARAMETERIZED_CRC_ENGINE_CORE_ASSERT_SVH
`define PARAMETERIZED_CRC_ENGINE_CORE_ASSERT_SVH

// The consequent must hold in the cycle after the antecedent, outside reset.
`define PCE_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("%m: check failed");

// The consequent must hold in the same cycle as the antecedent, outside reset.
`define PCE_ASSERT_SAME(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("%m: check failed");

// The expression must hold at every edge, reset included.
`define PCE_ASSERT_ALWAYS(label, expr) \
   label: assert property (@(posedge clock) (expr)) \
      else $error("%m: check failed");

`endif

@@ design/pce_pkg.sv @@
// ---------------------------------------------------------------------------
// CRC engine package
// Widths, register indexes, shared types and bit helpers.
// ---------------------------------------------------------------------------
`default_nettype none

package pce_pkg;

   // Widest CRC supported; also the width of the wide register and result fields.
   localparam int MAX_WIDTH   = 64;
   localparam int WIDTH_REG_W = 7;
   localparam int SHAMT_W     = $clog2(MAX_WIDTH);
   localparam int CSR_INDEX_W = 3;

   // Result queue and running state memory sizes.
   localparam int RSP_DEPTH    = 4;
   localparam int RSP_PTR_W    = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W    = $clog2(RSP_DEPTH + 1);
   localparam int STATE_DEPTH  = 1;
   localparam int STATE_ADDR_W = 1;

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CRC_WIDTH      = 3'd0,
      CSR_POLYNOMIAL     = 3'd1,
      CSR_INITIAL_VALUE  = 3'd2,
      CSR_REFLECT_INPUT  = 3'd3,
      CSR_REFLECT_OUTPUT = 3'd4,
      CSR_FINAL_XOR      = 3'd5
   } csr_index_type;

   // Model values prepared from the configuration registers.
   typedef struct packed {
      logic [MAX_WIDTH-1:0] mask;
      logic [MAX_WIDTH-1:0] topbit;
      logic [MAX_WIDTH-1:0] poly;
      logic [MAX_WIDTH-1:0] rpoly;
      logic [MAX_WIDTH-1:0] init_start;
      logic [MAX_WIDTH-1:0] fxor;
      logic                 refin;
      logic                 refout;
      logic [SHAMT_W-1:0]   shamt;
   } cfg_type;

   // Full-width bit reversal; pure wiring.
   function automatic logic [MAX_WIDTH-1:0] reverse_bits(input logic [MAX_WIDTH-1:0] v);
      logic [MAX_WIDTH-1:0] r;
      for (int i = 0; i < MAX_WIDTH; i++) begin
         r[i] = v[MAX_WIDTH-1-i];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

@@ design/parameterized_crc_engine_core.sv @@
// A last word's CRC passes the capture, finish and result queue registers to the result channel.
// Throughput: one message byte per cycle when input is not stalled, set by the read, fold and
// write-back of the running CRC memory, with the next read forwarded from the word just folded.
// Apart from reset, input stalls only when four results are outstanding, in flight or queued.
// Reset (synchronous, active high) restores the default CRC-32 model and a zero running CRC;
// both channels stay not ready during reset and for the first cycle after it.
// ---------------------------------------------------------------------------
// Parameterized CRC engine core
// Byte-wide CRC engine under a configurable 1 to 64 bit model, with the
// running CRC kept in a one-entry memory.
// ---------------------------------------------------------------------------
`default_nettype none

module parameterized_crc_engine_core (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [7:0]                      req_data_byte,
   input  wire logic                            req_first_byte,
   input  wire logic                            req_last_byte,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic      [pce_pkg::MAX_WIDTH-1:0]   rsp_crc_value,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [pce_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [pce_pkg::MAX_WIDTH-1:0]   csr_data
);

   pce_pkg::cfg_type cfg;

   logic run_ff;
   logic req_fire;
   logic rsp_fire;

   logic [pce_pkg::RSP_CNT_W-1:0] pending_ff;
   logic [pce_pkg::RSP_CNT_W-1:0] pending_in;

   logic       s1_valid_ff;
   logic [7:0] s1_byte_ff;
   logic       s1_first_ff;
   logic       s1_last_ff;
   logic       s1_fwd_ff;
   logic       s1_known_ff;
   logic       state_written_ff;

   logic [pce_pkg::MAX_WIDTH-1:0] ram_rd_data;
   logic [pce_pkg::MAX_WIDTH-1:0] s1_start;
   logic [pce_pkg::MAX_WIDTH-1:0] s1_next;

   logic                          s2_valid_ff;
   logic [pce_pkg::MAX_WIDTH-1:0] s2_crc_ff;
   logic [pce_pkg::MAX_WIDTH-1:0] s2_oriented;
   logic [pce_pkg::MAX_WIDTH-1:0] s2_result;

   // Handshakes: input is throttled by outstanding results, not by the pipeline.
   assign req_ready = run_ff && !reset && (pending_ff != pce_pkg::RSP_CNT_W'(pce_pkg::RSP_DEPTH));
   assign csr_ready = run_ff && !reset;
   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = rsp_valid && rsp_ready;

   pce_cfg u_cfg (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid && csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg)
   );

   // Credit count of results that are in flight or queued.
   always_comb begin
      pending_in = pending_ff;
      if ((req_fire && req_last_byte) && !rsp_fire) begin
         pending_in = pending_ff + pce_pkg::RSP_CNT_W'(1);
      end else if (rsp_fire && !(req_fire && req_last_byte)) begin
         pending_in = pending_ff - pce_pkg::RSP_CNT_W'(1);
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff           <= 1'b0;
         pending_ff       <= '0;
         s1_valid_ff      <= 1'b0;
         s2_valid_ff      <= 1'b0;
         state_written_ff <= 1'b0;
      end else begin
         run_ff      <= 1'b1;
         pending_ff  <= pending_in;
         s1_valid_ff <= req_fire;
         s2_valid_ff <= s1_valid_ff && s1_last_ff;
         if (s1_valid_ff) begin
            state_written_ff <= 1'b1;
         end
      end
   end

   // Capture the accepted word; note whether the memory read will miss the
   // write-back of the word now in the fold stage.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_byte_ff  <= req_data_byte;
         s1_first_ff <= req_first_byte;
         s1_last_ff  <= req_last_byte;
         s1_fwd_ff   <= s1_valid_ff;
         s1_known_ff <= state_written_ff;
      end
   end

   // Running CRC memory: read on acceptance, written back from the fold stage.
   pce_ram #(
      .WIDTH (pce_pkg::MAX_WIDTH),
      .DEPTH (pce_pkg::STATE_DEPTH)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (pce_pkg::STATE_ADDR_W'(0)),
      .wr_data (s1_next),
      .rd_en   (req_fire),
      .rd_addr (pce_pkg::STATE_ADDR_W'(0)),
      .rd_data (ram_rd_data)
   );

   // Starting value: reload on a first word, else forwarded or stored state.
   // An unwritten memory reads as the zero reset state.
   always_comb begin
      if (s1_first_ff) begin
         s1_start = cfg.init_start;
      end else if (s1_fwd_ff) begin
         s1_start = s2_crc_ff & cfg.mask;
      end else if (s1_known_ff) begin
         s1_start = ram_rd_data & cfg.mask;
      end else begin
         s1_start = '0;
      end
   end

   pce_fold u_fold (
      .crc_start (s1_start),
      .data_byte (s1_byte_ff),
      .cfg       (cfg),
      .crc_next  (s1_next)
   );

   // Finish stage register; it doubles as the forwarding source.
   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         s2_crc_ff <= s1_next;
      end
   end

   // Final CRC: reorient when the output order differs, then apply the final XOR.
   always_comb begin
      if (cfg.refin ^ cfg.refout) begin
         s2_oriented = pce_pkg::reverse_bits(s2_crc_ff) >> cfg.shamt;
      end else begin
         s2_oriented = s2_crc_ff;
      end
      s2_result = (s2_oriented ^ cfg.fxor) & cfg.mask;
   end

   pce_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (s2_valid_ff),
      .push_data (s2_result),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_crc_value)
   );

endmodule

`default_nettype wire

@@ design/pce_ram.sv @@
// ---------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered read.
// ---------------------------------------------------------------------------
`default_nettype none

module pce_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic                                   rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port: old data is returned when read and write meet.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ design/pce_cfg.sv @@
// ---------------------------------------------------------------------------
// CRC engine configuration
// Holds the model registers and prepares the width-dependent values.
// ---------------------------------------------------------------------------
`default_nettype none

module pce_cfg (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            wr_en,
   input  wire logic [pce_pkg::CSR_INDEX_W-1:0] wr_index,
   input  wire logic [pce_pkg::MAX_WIDTH-1:0]   wr_data,
   output pce_pkg::cfg_type                     cfg
);

   logic [pce_pkg::WIDTH_REG_W-1:0] width_ff;
   logic [pce_pkg::MAX_WIDTH-1:0]   poly_ff;
   logic [pce_pkg::MAX_WIDTH-1:0]   init_ff;
   logic                            refin_ff;
   logic                            refout_ff;
   logic [pce_pkg::MAX_WIDTH-1:0]   fxor_ff;

   logic [pce_pkg::WIDTH_REG_W-1:0] eff_width;
   logic [pce_pkg::WIDTH_REG_W-1:0] span;
   logic [pce_pkg::SHAMT_W-1:0]     shamt;
   logic [pce_pkg::MAX_WIDTH-1:0]   mask;
   pce_pkg::cfg_type                derived_in;
   pce_pkg::cfg_type                derived_ff;

   // Register writes; indexes beyond the list are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= pce_pkg::WIDTH_REG_W'(32);
         poly_ff   <= pce_pkg::MAX_WIDTH'(64'h0000_0000_04C1_1DB7);
         init_ff   <= pce_pkg::MAX_WIDTH'(64'h0000_0000_FFFF_FFFF);
         refin_ff  <= 1'b1;
         refout_ff <= 1'b1;
         fxor_ff   <= pce_pkg::MAX_WIDTH'(64'h0000_0000_FFFF_FFFF);
      end else if (wr_en) begin
         unique case (pce_pkg::csr_index_type'(wr_index))
            pce_pkg::CSR_CRC_WIDTH:      width_ff  <= wr_data[pce_pkg::WIDTH_REG_W-1:0];
            pce_pkg::CSR_POLYNOMIAL:     poly_ff   <= wr_data;
            pce_pkg::CSR_INITIAL_VALUE:  init_ff   <= wr_data;
            pce_pkg::CSR_REFLECT_INPUT:  refin_ff  <= wr_data[0];
            pce_pkg::CSR_REFLECT_OUTPUT: refout_ff <= wr_data[0];
            pce_pkg::CSR_FINAL_XOR:      fxor_ff   <= wr_data;
            default: begin
            end
         endcase
      end
   end

   // Saturate the width into range and derive the shift that aligns it.
   always_comb begin
      if (width_ff == '0) begin
         eff_width = pce_pkg::WIDTH_REG_W'(1);
      end else if (width_ff > pce_pkg::WIDTH_REG_W'(pce_pkg::MAX_WIDTH)) begin
         eff_width = pce_pkg::WIDTH_REG_W'(pce_pkg::MAX_WIDTH);
      end else begin
         eff_width = width_ff;
      end
      span  = pce_pkg::WIDTH_REG_W'(pce_pkg::MAX_WIDTH) - eff_width;
      shamt = span[pce_pkg::SHAMT_W-1:0];
      mask  = {pce_pkg::MAX_WIDTH{1'b1}} >> shamt;
   end

   // Prepared values; a reflection over the width is a full reversal shifted down.
   always_comb begin
      derived_in.mask   = mask;
      derived_in.topbit = {1'b1, {(pce_pkg::MAX_WIDTH-1){1'b0}}} >> shamt;
      derived_in.poly   = poly_ff & mask;
      derived_in.rpoly  = pce_pkg::reverse_bits(poly_ff) >> shamt;
      if (refin_ff) begin
         derived_in.init_start = pce_pkg::reverse_bits(init_ff) >> shamt;
      end else begin
         derived_in.init_start = init_ff & mask;
      end
      derived_in.fxor   = fxor_ff & mask;
      derived_in.refin  = refin_ff;
      derived_in.refout = refout_ff;
      derived_in.shamt  = shamt;
   end

   always_ff @(posedge clock) begin
      derived_ff <= derived_in;
   end

   assign cfg = derived_ff;

endmodule

`default_nettype wire

@@ design/pce_fold.sv @@
// ---------------------------------------------------------------------------
// CRC byte fold
// Eight-step bitwise division of one byte into the running CRC.
// ---------------------------------------------------------------------------
`default_nettype none

module pce_fold (
   input  wire logic [pce_pkg::MAX_WIDTH-1:0] crc_start,
   input  wire logic [7:0]                    data_byte,
   input  wire pce_pkg::cfg_type              cfg,
   output logic      [pce_pkg::MAX_WIDTH-1:0] crc_next
);

   logic [pce_pkg::MAX_WIDTH-1:0] crc;
   logic                          fb;

   // Reflected form shifts right with feedback from bit 0; normal form shifts
   // left with feedback from the top bit in use.
   always_comb begin
      crc = crc_start;
      fb  = 1'b0;
      for (int k = 0; k < 8; k++) begin
         if (cfg.refin) begin
            fb  = crc[0] ^ data_byte[3'(k)];
            crc = (crc >> 1) ^ (fb ? cfg.rpoly : '0);
         end else begin
            fb  = (|(crc & cfg.topbit)) ^ data_byte[3'(7 - k)];
            crc = ((crc << 1) & cfg.mask) ^ (fb ? cfg.poly : '0);
         end
      end
      crc_next = crc & cfg.mask;
   end

endmodule

`default_nettype wire

@@ design/pce_rsp_fifo.sv @@
// ---------------------------------------------------------------------------
// CRC result queue
// Small register queue that holds finished CRC words for the result channel.
// ---------------------------------------------------------------------------
`default_nettype none

module pce_rsp_fifo (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          push,
   input  wire logic [pce_pkg::MAX_WIDTH-1:0] push_data,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic      [pce_pkg::MAX_WIDTH-1:0] rsp_data
);

   logic [pce_pkg::MAX_WIDTH-1:0] entry_ff [pce_pkg::RSP_DEPTH];
   logic [pce_pkg::RSP_PTR_W-1:0] wr_ptr_ff;
   logic [pce_pkg::RSP_PTR_W-1:0] rd_ptr_ff;
   logic [pce_pkg::RSP_CNT_W-1:0] count_ff;
   logic [pce_pkg::RSP_CNT_W-1:0] count_in;
   logic                          pop;

   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = entry_ff[rd_ptr_ff];
   assign pop       = rsp_valid && rsp_ready;

   // Entry storage; the upstream credit count keeps the queue from overflowing.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + pce_pkg::RSP_CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - pce_pkg::RSP_CNT_W'(1);
      end
   end

   // Pointers and fill level.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + pce_pkg::RSP_PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + pce_pkg::RSP_PTR_W'(1);
         end
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

@@ design/pce_checker.sv @@
// ---------------------------------------------------------------------------
// CRC engine port checker
// Watches the top-level ports for ordering, latency and reset behaviour.
// ---------------------------------------------------------------------------
`default_nettype none

`include "parameterized_crc_engine_core_assert.svh"

module pce_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_ready,
   input wire logic                          req_last_byte,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic [pce_pkg::MAX_WIDTH-1:0] rsp_crc_value,
   input wire logic                          csr_ready
);

   logic [3:0] pend_ff;
   logic       last_fire;
   logic       rsp_fire;
   logic       idle_last_fire;

   assign last_fire      = req_valid && req_ready && req_last_byte;
   assign rsp_fire       = rsp_valid && rsp_ready;
   assign idle_last_fire = last_fire && (pend_ff == 4'd0);

   // Number of last words accepted whose CRC has not yet been taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 4'd0;
      end else begin
         pend_ff <= pend_ff + {3'd0, last_fire} - {3'd0, rsp_fire};
      end
   end

   // A stalled result word holds its value.
   `PCE_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_crc_value))

   // No result word appears without a last word behind it.
   `PCE_ASSERT_SAME(a_no_spurious, rsp_valid, pend_ff != 4'd0)

   // An idle engine gives the CRC of a last word once it has passed the capture, finish and queue registers.
   `PCE_ASSERT_SAME(a_latency, $past(idle_last_fire, 3) && !$past(reset, 1) && !$past(reset, 2), rsp_valid)

   // Neither channel takes a word during reset.
   `PCE_ASSERT_ALWAYS(a_reset_block, !reset || (!req_ready && !csr_ready))

endmodule

bind parameterized_crc_engine_core pce_checker u_pce_checker (.*);

`default_nettype wire
